// ===== sv/sts_pkg.sv =====
package sts_pkg;

    // Frame geometry
    localparam int CAPTURE_DEPTH = 300;
    localparam int SEARCH_SPAN   = 200;
    localparam int SPAN_EFF      = (SEARCH_SPAN < CAPTURE_DEPTH) ? SEARCH_SPAN : CAPTURE_DEPTH;
    localparam int ADDR_W        = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
    localparam int SCAN_W        = (SPAN_EFF > 1) ? $clog2(SPAN_EFF) : 1;

    // Field widths
    localparam int ADC_W    = 12;
    localparam int MV_W     = 14;
    localparam int PEAK_W   = 13;
    localparam int TRIG_W   = 8;
    localparam int DI_W     = 7;
    localparam int CENTER_W = 7;
    localparam int HSPAN_W  = 10;
    localparam int ROW_W    = 19;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 2;

    // ADC to millivolt conversion: v = 5000 - (adc * 6600) >> 12
    localparam int V_OFFSET    = 5000;
    localparam int ADC_GAIN    = 6600;
    localparam int GAIN_W      = 13;
    localparam int CONV_PROD_W = ADC_W + GAIN_W;

    // Display arithmetic
    localparam int SUM_W   = ((TRIG_W > DI_W) ? TRIG_W : DI_W) + 1;
    localparam int DIFF_W  = MV_W + 3;
    localparam int SCALE_W = HSPAN_W + 4;
    localparam int PROD_W  = DIFF_W + SCALE_W - 1;
    localparam int MAG_W   = PROD_W;
    localparam int ROWX_W  = MAG_W + 2;
    localparam int DCNT_W  = $clog2(MAG_W + 1);

    localparam int ROW_MAX = 262143;
    localparam int ROW_MIN = -262144;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPAN     = 2'd3;

    // Reset values of the registers
    localparam logic signed [MV_W-1:0] TRIGGER_LEVEL_RST = 14'sd1000;
    localparam logic [PEAK_W-1:0]      MIN_AMPLITUDE_RST = 13'd300;
    localparam logic [CENTER_W-1:0]    CENTER_ROW_RST    = 7'd30;
    localparam logic [HSPAN_W-1:0]     HALF_SPAN_RST     = 10'd180;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== sv/sts_div.sv =====
module sts_div
    import sts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MAG_W-1:0]  dividend,
    input  logic [PEAK_W-1:0] divisor,
    output div_status_t       status,
    output logic [MAG_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [PEAK_W-1:0] rem_reg, rem_next;
    logic [PEAK_W-1:0] dvs_reg, dvs_next;
    logic [PEAK_W:0]   trial;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(MAG_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[MAG_W-2:0], fits};
            rem_next = fits ? PEAK_W'(trial - {1'b0, dvs_reg}) : trial[PEAK_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== sv/scope_trigger_and_scale.sv =====
// Channel | Direction | Handshake           | Words
// --------+-----------+---------------------+-------------------------------------------
// in      | input     | in_valid / in_ready | cmd, sample, display_index
// out     | output    | out_valid/out_ready | kind, peak_mv, trigger_index,
//         |           |                     | low_amplitude, row_q8
// cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A sample load converts and stores the sample; the last load of a frame then scans
// the search span through the single store read port, reading and checking each entry.
// A display read wraps the index into the store, reads, multiplies and runs the
// bit-serial divider; with no scaling peak it skips the divide and gives the center row.
// Reset sets the registers to their defaults; the sample store is not cleared.
// The output register holds a word while out_ready is low; a new word is taken
// meanwhile, and its result waits in the sequencer until the register frees.
module scope_trigger_and_scale
    import sts_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [ADC_W-1:0]           sample,
    input  logic [DI_W-1:0]            display_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       kind,
    output logic [PEAK_W-1:0]          peak_mv,
    output logic [TRIG_W-1:0]          trigger_index,
    output logic                       low_amplitude,
    output logic signed [ROW_W-1:0]    row_q8,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CONV   = 4'd1;
    localparam logic [3:0] S_STORE  = 4'd2;
    localparam logic [3:0] S_SRD    = 4'd3;
    localparam logic [3:0] S_SCHK   = 4'd4;
    localparam logic [3:0] S_SUM    = 4'd5;
    localparam logic [3:0] S_WRAP   = 4'd6;
    localparam logic [3:0] S_DRD    = 4'd7;
    localparam logic [3:0] S_DMUL   = 4'd8;
    localparam logic [3:0] S_DSTART = 4'd9;
    localparam logic [3:0] S_DDIV   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    localparam logic signed [ROWX_W-1:0] ROWX_MAX = ROWX_W'(ROW_MAX);
    localparam logic signed [ROWX_W-1:0] ROWX_MIN = ROWX_W'(ROW_MIN);

    logic [3:0]                state_reg, state_next;
    logic [ADC_W-1:0]          adc_reg, adc_next;
    logic signed [MV_W-1:0]    v_reg, v_next;
    logic [ADDR_W-1:0]         wr_index_reg, wr_index_next;
    logic [PEAK_W-1:0]         peak_reg, peak_next;
    logic [TRIG_W-1:0]         held_reg, held_next;
    logic [PEAK_W-1:0]         scale_reg, scale_next;
    logic [SCAN_W-1:0]         scan_reg, scan_next;
    logic                      seen_low_reg, seen_low_next;
    logic [SUM_W-1:0]          disp_reg, disp_next;
    logic signed [PROD_W-1:0]  num_reg, num_next;
    logic                      neg_reg, neg_next;

    logic                      pend_kind_reg, pend_kind_next;
    logic [PEAK_W-1:0]         pend_peak_reg, pend_peak_next;
    logic [TRIG_W-1:0]         pend_trig_reg, pend_trig_next;
    logic                      pend_low_reg, pend_low_next;
    logic signed [ROW_W-1:0]   pend_row_reg, pend_row_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_kind_reg, out_kind_next;
    logic [PEAK_W-1:0]         out_peak_reg, out_peak_next;
    logic [TRIG_W-1:0]         out_trig_reg, out_trig_next;
    logic                      out_low_reg, out_low_next;
    logic signed [ROW_W-1:0]   out_row_reg, out_row_next;

    logic signed [MV_W-1:0]    level_reg, level_next;
    logic [PEAK_W-1:0]         min_amp_reg, min_amp_next;
    logic [CENTER_W-1:0]       center_reg, center_next;
    logic [HSPAN_W-1:0]        hspan_reg, hspan_next;

    // Sample store
    logic signed [MV_W-1:0]    mem [CAPTURE_DEPTH];
    logic signed [MV_W-1:0]    rdata_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      mem_we;

    logic [CONV_PROD_W-1:0]    conv_prod;
    logic signed [MV_W:0]      conv_v;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W:0]    mul_full;
    logic [MAG_W-1:0]          mag;
    logic signed [ROWX_W-1:0]  q_signed;
    logic signed [ROWX_W-1:0]  row_wide;
    logic [ROWX_W-1:0]         row_base;
    logic                      div_start;
    div_status_t               div_st;
    logic [MAG_W-1:0]          div_quo;
    logic                      out_free;
    logic                      accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Convert the raw code to millivolts
    assign conv_prod = CONV_PROD_W'(adc_reg) * CONV_PROD_W'(ADC_GAIN);
    assign conv_v    = $signed((MV_W + 1)'(V_OFFSET))
                     - $signed({2'b00, conv_prod[CONV_PROD_W-1:ADC_W]});

    // Scale term (2v - P) * half_span * 16
    assign diff     = $signed({{2{rdata_reg[MV_W-1]}}, rdata_reg, 1'b0})
                    - $signed({{(DIFF_W - PEAK_W){1'b0}}, scale_reg});
    assign mul_full = diff * $signed({1'b0, hspan_reg, 4'b0000});
    assign mag      = num_reg[PROD_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);

    // Row from the quotient, saturated
    assign row_base = {{(ROWX_W - CENTER_W - 8){1'b0}}, center_reg, 8'b0};
    assign q_signed = neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    assign row_wide = $signed(row_base) - q_signed;

    assign mem_we    = (state_reg == S_STORE);
    assign rd_addr   = (state_reg == S_DRD) ? ADDR_W'(disp_reg) : ADDR_W'(scan_reg);
    assign div_start = (state_reg == S_DSTART);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_index_reg] <= v_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    sts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (scale_reg),
        .status   (div_st),
        .quotient (div_quo)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        adc_next       = adc_reg;
        v_next         = v_reg;
        wr_index_next  = wr_index_reg;
        peak_next      = peak_reg;
        held_next      = held_reg;
        scale_next     = scale_reg;
        scan_next      = scan_reg;
        seen_low_next  = seen_low_reg;
        disp_next      = disp_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        pend_kind_next = pend_kind_reg;
        pend_peak_next = pend_peak_reg;
        pend_trig_next = pend_trig_reg;
        pend_low_next  = pend_low_reg;
        pend_row_next  = pend_row_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    adc_next  = sample;
                    disp_next = SUM_W'(held_reg) + SUM_W'(display_index);
                    if (!cmd)
                    begin
                        state_next = S_CONV;
                    end
                    else if (scale_reg == '0)
                    begin
                        pend_kind_next = 1'b1;
                        pend_peak_next = '0;
                        pend_trig_next = '0;
                        pend_low_next  = 1'b0;
                        pend_row_next  = ROW_W'(row_base);
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_WRAP;
                    end
                end
            end
            S_CONV:
            begin
                v_next     = conv_v[MV_W-1:0];
                state_next = S_STORE;
            end
            S_STORE:
            begin
                // Track the peak and advance the write pointer
                if (v_reg > $signed({1'b0, peak_reg}))
                begin
                    peak_next = v_reg[PEAK_W-1:0];
                end
                if (wr_index_reg == ADDR_W'(CAPTURE_DEPTH - 1))
                begin
                    wr_index_next = '0;
                    scan_next     = '0;
                    seen_low_next = 1'b0;
                    state_next    = S_SRD;
                end
                else
                begin
                    wr_index_next = wr_index_reg + 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SRD:
            begin
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                // Look for a drop below the level, then a rise above it
                if (seen_low_reg && (rdata_reg > level_reg))
                begin
                    held_next  = TRIG_W'(scan_reg);
                    state_next = S_SUM;
                end
                else
                begin
                    if (rdata_reg < level_reg)
                    begin
                        seen_low_next = 1'b1;
                    end
                    if (scan_reg == SCAN_W'(SPAN_EFF - 1))
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
            end
            S_SUM:
            begin
                pend_kind_next = 1'b0;
                pend_peak_next = peak_reg;
                pend_trig_next = held_reg;
                pend_low_next  = (peak_reg <= min_amp_reg);
                pend_row_next  = '0;
                if (peak_reg > min_amp_reg)
                begin
                    scale_next = peak_reg;
                end
                peak_next  = '0;
                state_next = S_OUT;
            end
            S_WRAP:
            begin
                // Reduce the display index modulo the store depth
                if (disp_reg >= SUM_W'(CAPTURE_DEPTH))
                begin
                    disp_next = disp_reg - SUM_W'(CAPTURE_DEPTH);
                end
                else
                begin
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                num_next   = mul_full[PROD_W-1:0];
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                neg_next   = num_reg[PROD_W-1];
                state_next = S_DDIV;
            end
            S_DDIV:
            begin
                if (div_st.done)
                begin
                    pend_kind_next = 1'b1;
                    pend_peak_next = '0;
                    pend_trig_next = '0;
                    pend_low_next  = 1'b0;
                    priority if (row_wide > ROWX_MAX)
                    begin
                        pend_row_next = ROW_W'(ROWX_MAX);
                    end
                    else if (row_wide < ROWX_MIN)
                    begin
                        pend_row_next = ROW_W'(ROWX_MIN);
                    end
                    else
                    begin
                        pend_row_next = ROW_W'(row_wide);
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load a word when free, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_peak_next  = out_peak_reg;
        out_trig_next  = out_trig_reg;
        out_low_next   = out_low_reg;
        out_row_next   = out_row_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = pend_kind_reg;
            out_peak_next  = pend_peak_reg;
            out_trig_next  = pend_trig_reg;
            out_low_next   = pend_low_reg;
            out_row_next   = pend_row_reg;
        end
    end

    // Configuration writes
    always_comb
    begin
        level_next   = level_reg;
        min_amp_next = min_amp_reg;
        center_next  = center_reg;
        hspan_next   = hspan_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_LEVEL: level_next   = $signed(cfg_data[MV_W-1:0]);
                CFG_MIN_AMPLITUDE: min_amp_next = cfg_data[PEAK_W-1:0];
                CFG_CENTER_ROW:    center_next  = cfg_data[CENTER_W-1:0];
                CFG_HALF_SPAN:     hspan_next   = cfg_data[HSPAN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            adc_reg       <= '0;
            v_reg         <= '0;
            wr_index_reg  <= '0;
            peak_reg      <= '0;
            held_reg      <= '0;
            scale_reg     <= '0;
            scan_reg      <= '0;
            seen_low_reg  <= 1'b0;
            disp_reg      <= '0;
            num_reg       <= '0;
            neg_reg       <= 1'b0;
            pend_kind_reg <= 1'b0;
            pend_peak_reg <= '0;
            pend_trig_reg <= '0;
            pend_low_reg  <= 1'b0;
            pend_row_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
            out_peak_reg  <= '0;
            out_trig_reg  <= '0;
            out_low_reg   <= 1'b0;
            out_row_reg   <= '0;
            level_reg     <= TRIGGER_LEVEL_RST;
            min_amp_reg   <= MIN_AMPLITUDE_RST;
            center_reg    <= CENTER_ROW_RST;
            hspan_reg     <= HALF_SPAN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            adc_reg       <= adc_next;
            v_reg         <= v_next;
            wr_index_reg  <= wr_index_next;
            peak_reg      <= peak_next;
            held_reg      <= held_next;
            scale_reg     <= scale_next;
            scan_reg      <= scan_next;
            seen_low_reg  <= seen_low_next;
            disp_reg      <= disp_next;
            num_reg       <= num_next;
            neg_reg       <= neg_next;
            pend_kind_reg <= pend_kind_next;
            pend_peak_reg <= pend_peak_next;
            pend_trig_reg <= pend_trig_next;
            pend_low_reg  <= pend_low_next;
            pend_row_reg  <= pend_row_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_peak_reg  <= out_peak_next;
            out_trig_reg  <= out_trig_next;
            out_low_reg   <= out_low_next;
            out_row_reg   <= out_row_next;
            level_reg     <= level_next;
            min_amp_reg   <= min_amp_next;
            center_reg    <= center_next;
            hspan_reg     <= hspan_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign peak_mv       = out_peak_reg;
    assign trigger_index = out_trig_reg;
    assign low_amplitude = out_low_reg;
    assign row_q8        = out_row_reg;

`ifndef SYNTHESIS
    // The divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.busy |-> (state_reg == S_DDIV))
        else $error("divider busy outside the divide step");

    // Starting a divide needs a nonzero scaling peak
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (scale_reg != '0))
        else $error("divide started with zero scaling peak");

    // The write pointer stays inside the store
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_index_reg <= ADDR_W'(CAPTURE_DEPTH - 1))
        else $error("write index past the store");

    // A summary word carries a trigger index inside the search span
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_kind_reg) |-> (out_trig_reg <= TRIG_W'(SPAN_EFF - 1)))
        else $error("trigger index outside the search span");

    // Leaving the result step always loads the output register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_free) |=> out_valid_reg)
        else $error("result step left without loading the output");
`endif

endmodule
